### hw/rtl/sjag_pkg.sv
// Shared types, constants and helper tables for the serpentine joint angle generator.
// No dependencies; used by every module under hw/rtl.
package sjag_pkg;

    localparam int JOINT_COUNT_DEF = 4;
    localparam int SINE_DEPTH_DEF  = 256;
    localparam int SLOT_NUM        = 8;

    localparam int ANGLE_W   = 16;
    localparam int ENTRY_W   = 17;
    localparam int TRIM_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [1:0] MODE_FORWARD  = 2'd0;
    localparam logic [1:0] MODE_LATERAL  = 2'd1;
    localparam logic [1:0] MODE_CIRCULAR = 2'd2;
    localparam logic [1:0] MODE_TURN_R   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_SLOT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWING_AMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC  = 3'd3;

    localparam logic [2:0]  RST_JOINT_SLOT  = 3'd0;
    localparam logic [14:0] RST_BASE_OFFSET = 15'd0;
    localparam logic [12:0] RST_SWING_AMP   = 13'd2880;
    localparam logic [14:0] RST_PHASE_INC   = 15'd2949;

    localparam logic [15:0] LATERAL_OFFSET = 16'd16384;
    localparam logic [15:0] STEP_FLOOR     = 16'd384;
    localparam logic [15:0] STEP_MARGIN    = 16'd192;

    typedef struct packed {
        logic       enable;
        logic [1:0] mode;
    } t_in;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] target_angle;
        logic                      clamped;
        logic [15:0]               clamp_total;
    } t_out;

    typedef struct packed {
        logic emit;
        logic clr;
    } t_item_ctl;

    // 60 degrees per joint, rounded, modulo one turn
    function automatic logic [15:0] slot_phase_lead(input logic [2:0] n);
        logic [15:0] v;
        case (n)
            3'd0:    v = 16'd0;
            3'd1:    v = 16'd10923;
            3'd2:    v = 16'd21845;
            3'd3:    v = 16'd32768;
            3'd4:    v = 16'd43691;
            3'd5:    v = 16'd54613;
            3'd6:    v = 16'd0;
            3'd7:    v = 16'd10923;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/sjag_sine_rom.sv
// Constant Q15 sine table, built at elaboration, combinational lookup.
// Depends on sjag_pkg.
module sjag_sine_rom import sjag_pkg::*; #(
    parameter int DEPTH = SINE_DEPTH_DEF
) (
    input  logic [$clog2(DEPTH)-1:0]  i_idx,
    output logic signed [ENTRY_W-1:0] o_entry
);

    logic signed [ENTRY_W-1:0] w_rom [DEPTH];

    for (genvar gk = 0; gk < DEPTH; gk++) begin : g_rom
        localparam longint T0  = (longint'(gk) * 65536) / DEPTH;
        localparam longint T   = (T0 >= 32768) ? T0 - 32768 : T0;
        localparam longint M   = T * (32768 - T);
        localparam longint DEN = (longint'(5) << 28) - M;
        localparam longint Q   = ((M << 17) + DEN / 2) / DEN;
        localparam longint V   = (T0 >= 32768) ? -Q : Q;
        assign w_rom[gk] = ENTRY_W'(V);
    end

    assign o_entry = w_rom[i_idx];

endmodule

### hw/rtl/sjag_step_calc.sv
// Serial computation of the slew step from swing amplitude and phase increment.
// Restoring divider, one quotient bit per cycle. Depends on sjag_pkg.
module sjag_step_calc import sjag_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_swing_amp,
    input  logic [14:0] i_phase_inc,
    output logic        o_busy,
    output logic [15:0] o_step
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MULT  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [30:0] DEN_BASE = 31'd1342177280;

    logic [2:0]  r_state, n_state;
    logic        r_pend, n_pend;
    logic [27:0] r_m;
    logic [45:0] r_rem;
    logic [45:0] r_dsh;
    logic [15:0] r_quot;
    logic [3:0]  r_cnt;
    logic [28:0] r_prod;
    logic [15:0] r_step;

    logic [13:0] w_t;
    logic [29:0] w_m_full;
    logic [30:0] w_den;
    logic        w_ge;
    logic [29:0] w_scaled;
    logic [15:0] w_s;
    logic [15:0] w_s_floor;

    assign w_t      = i_phase_inc[14:1];
    assign w_m_full = {16'd0, w_t} * {14'd0, 16'd32768 - {2'd0, w_t}};
    assign w_den    = DEN_BASE - {3'd0, r_m};
    assign w_ge     = r_rem >= r_dsh;
    assign w_scaled = {1'b0, r_prod} + 30'd8192;
    assign w_s      = w_scaled[29:14];
    assign w_s_floor = (w_s < STEP_FLOOR) ? STEP_FLOOR : w_s;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend || i_start;
        unique case (r_state)
            ST_IDLE: begin
                if (r_pend) begin
                    n_state = ST_MULT;
                    n_pend  = i_start;
                end
            end
            ST_MULT:  n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 4'd0) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MULT: begin
                r_m <= w_m_full[27:0];
            end
            ST_LOAD: begin
                r_rem  <= {1'b0, r_m, 17'd0} + {16'd0, w_den[30:1]};
                r_dsh  <= {w_den, 15'd0};
                r_quot <= '0;
                r_cnt  <= 4'd15;
            end
            ST_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quot <= {r_quot[14:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - 4'd1;
            end
            ST_SCALE: begin
                r_prod <= {16'd0, i_swing_amp} * {13'd0, r_quot};
            end
            ST_DONE: begin
                r_step <= w_s_floor + STEP_MARGIN;
            end
            default: begin
            end
        endcase
    end

    assign o_busy = r_pend || i_start || (r_state != ST_IDLE);
    assign o_step = r_step;

endmodule

### hw/rtl/sjag_slew_limiter.sv
// Slew limiter with target history, clamp counter and output register.
// Depends on sjag_pkg.
module sjag_slew_limiter import sjag_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_item_ctl                 i_ctl,
    input  logic signed [ANGLE_W-1:0] i_raw,
    input  logic [15:0]               i_step,
    output logic                      o_take,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out                      o_out_data
);

    logic                      r_prev_valid;
    logic signed [ANGLE_W-1:0] r_prev;
    logic [15:0]               r_count;
    logic                      r_out_valid;
    t_out                      r_out;

    logic               w_hist;
    logic signed [16:0] w_delta;
    logic signed [16:0] w_step_s;
    logic signed [16:0] w_result;
    logic               w_clamped;
    logic [15:0]        w_count;

    assign w_hist   = r_prev_valid && !i_ctl.clr;
    assign w_delta  = {i_raw[15], i_raw} - {r_prev[15], r_prev};
    assign w_step_s = {1'b0, i_step};

    always_comb begin
        w_result  = {i_raw[15], i_raw};
        w_clamped = 1'b0;
        if (w_hist && (w_delta > w_step_s)) begin
            w_result  = {r_prev[15], r_prev} + w_step_s;
            w_clamped = 1'b1;
        end else if (w_hist && (w_delta < -w_step_s)) begin
            w_result  = {r_prev[15], r_prev} - w_step_s;
            w_clamped = 1'b1;
        end
    end

    assign w_count = r_count + {15'd0, w_clamped};
    assign o_take  = i_valid && (!i_ctl.emit || !r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take && i_ctl.emit) begin
                r_prev_valid <= 1'b1;
                r_count      <= w_count;
                r_out_valid  <= 1'b1;
            end else begin
                if (o_take && i_ctl.clr) begin
                    r_prev_valid <= 1'b0;
                end
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_ctl.emit) begin
            r_prev             <= w_result[15:0];
            r_out.target_angle <= w_result[15:0];
            r_out.clamped      <= w_clamped;
            r_out.clamp_total  <= w_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/serpentine_joint_angle_generator.sv
// Serpentine gait joint angle generator: one slew-limited servo target per enabled tick.
// Takes one transaction per cycle while neither the output nor the slew step calculation
// stalls it; a result is presented from the output register after passing the input,
// stage 2 and stage 3 registers (phase and table lookup, amplitude multiply and trim, slew
// limit). The input stalls after reset and after each write to swing_amplitude or
// phase_increment, while the slew step is recomputed by the serial divider at one quotient
// bit per cycle. Disabled ticks and slots at or beyond JOINT_COUNT produce no output
// transaction. Depends on sjag_pkg, sjag_sine_rom, sjag_step_calc and sjag_slew_limiter.
module serpentine_joint_angle_generator import sjag_pkg::*; #(
    parameter int JOINT_COUNT      = JOINT_COUNT_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = 16 + $clog2(SINE_TABLE_DEPTH + 1);

    // configuration
    logic [2:0]  r_joint_slot;
    logic [14:0] r_base_offset;
    logic [12:0] r_swing_amp;
    logic [14:0] r_phase_inc;

    logic w_cfg_wr;
    logic w_step_start;

    assign o_cfg_ready  = 1'b1;
    assign w_cfg_wr     = i_cfg_valid && o_cfg_ready;
    assign w_step_start = w_cfg_wr &&
                          ((i_cfg_index == CFG_SWING_AMP) || (i_cfg_index == CFG_PHASE_INC));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_slot  <= RST_JOINT_SLOT;
            r_base_offset <= RST_BASE_OFFSET;
            r_swing_amp   <= RST_SWING_AMP;
            r_phase_inc   <= RST_PHASE_INC;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_JOINT_SLOT:  r_joint_slot  <= i_cfg_data[2:0];
                CFG_BASE_OFFSET: r_base_offset <= i_cfg_data[14:0];
                CFG_SWING_AMP:   r_swing_amp   <= i_cfg_data[12:0];
                CFG_PHASE_INC:   r_phase_inc   <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // slew step
    logic        w_step_busy;
    logic [15:0] w_step;

    sjag_step_calc u_step_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_step_start),
        .i_swing_amp (r_swing_amp),
        .i_phase_inc (r_phase_inc),
        .o_busy      (w_step_busy),
        .o_step      (w_step)
    );

    // trim tables per slot
    logic signed [TRIM_W-1:0] w_trim_fwd  [SLOT_NUM];
    logic signed [TRIM_W-1:0] w_trim_turn [SLOT_NUM];

    for (genvar gs = 0; gs < SLOT_NUM; gs++) begin : g_trim
        localparam int N  = JOINT_COUNT - 1 - gs;
        localparam int K  = 2 * N - JOINT_COUNT + 1;
        localparam int NF = K * 256;
        localparam int NT = K * 480;
        localparam int TF = (gs >= JOINT_COUNT) ? 0 :
                            (NF >= 0) ? (2 * NF + JOINT_COUNT) / (2 * JOINT_COUNT) :
                            -((-2 * NF + JOINT_COUNT) / (2 * JOINT_COUNT));
        localparam int TT = (gs >= JOINT_COUNT) ? 0 :
                            (NT >= 0) ? (2 * NT + JOINT_COUNT) / (2 * JOINT_COUNT) :
                            -((-2 * NT + JOINT_COUNT) / (2 * JOINT_COUNT));
        assign w_trim_fwd[gs]  = TRIM_W'(TF);
        assign w_trim_turn[gs] = TRIM_W'(TT);
    end

    // pipeline handshake
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_take3;
    logic w_acc_in;
    logic w_adv1;

    assign w_rdy3     = !r_v3 || w_take3;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1 || w_step_busy;
    assign w_acc_in   = i_in_valid && !o_in_stall;
    assign w_adv1     = r_v1 && w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= w_acc_in;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: phase accumulator and table lookup
    t_in         r_in;
    logic [15:0] r_phase_acc;
    logic [1:0]  r_prev_mode;
    logic        r_prev_known;

    logic                      w_new_run;
    logic [15:0]               w_phase_new;
    logic [2:0]                w_n;
    logic                      w_slot_ok;
    logic [15:0]               w_ph;
    logic [PW-1:0]             w_tab_prod;
    logic [AW-1:0]             w_idx;
    logic signed [ENTRY_W-1:0] w_entry;
    t_item_ctl                 w_ctl1;

    assign w_new_run   = !r_prev_known || (r_prev_mode != r_in.mode);
    assign w_phase_new = (w_new_run ? 16'd0 : r_phase_acc) - {1'b0, r_phase_inc};
    assign w_n         = 3'(JOINT_COUNT - 1) - r_joint_slot;
    assign w_slot_ok   = {1'b0, r_joint_slot} < 4'(JOINT_COUNT);
    assign w_ph        = slot_phase_lead(w_n) + w_phase_new +
                         ((r_in.mode == MODE_LATERAL) ? LATERAL_OFFSET : 16'd0);
    assign w_tab_prod  = PW'(w_ph) * PW'(SINE_TABLE_DEPTH);
    assign w_idx       = w_tab_prod[16 +: AW];
    assign w_ctl1.emit = r_in.enable && w_slot_ok;
    assign w_ctl1.clr  = !r_in.enable || w_new_run;

    sjag_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_idx   (w_idx),
        .o_entry (w_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc  <= '0;
            r_prev_mode  <= MODE_FORWARD;
            r_prev_known <= 1'b0;
        end else if (w_adv1) begin
            if (r_in.enable) begin
                r_phase_acc  <= w_phase_new;
                r_prev_mode  <= r_in.mode;
                r_prev_known <= 1'b1;
            end else begin
                r_phase_acc  <= '0;
                r_prev_known <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_in <= i_in_data;
        end
    end

    // stage 2: amplitude scaling, trim and base offset
    logic signed [ENTRY_W-1:0] r_entry2;
    logic [1:0]                r_mode2;
    t_item_ctl                 r_ctl2;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_entry2 <= w_entry;
            r_mode2  <= r_in.mode;
            r_ctl2   <= w_ctl1;
        end
    end

    logic signed [30:0]        w_prod2;
    logic [30:0]               w_mag2;
    logic [30:0]               w_rnd2;
    logic [13:0]               w_swing_mag;
    logic signed [15:0]        w_swing2;
    logic signed [TRIM_W-1:0]  w_trim2;
    logic [16:0]               w_raw_sum;

    assign w_prod2     = 31'($signed({1'b0, r_swing_amp}) * r_entry2);
    assign w_mag2      = w_prod2[30] ? 31'(-w_prod2) : w_prod2;
    assign w_rnd2      = w_mag2 + 31'd16384;
    assign w_swing_mag = w_rnd2[28:15];
    assign w_swing2    = w_prod2[30] ? -$signed({2'b0, w_swing_mag}) : $signed({2'b0, w_swing_mag});

    always_comb begin
        case (r_mode2)
            MODE_FORWARD:  w_trim2 = w_trim_fwd[r_joint_slot];
            MODE_CIRCULAR: w_trim2 = -w_trim_turn[r_joint_slot];
            MODE_TURN_R:   w_trim2 = w_trim_turn[r_joint_slot];
            default:       w_trim2 = '0;
        endcase
    end

    assign w_raw_sum = {{2{r_base_offset[14]}}, r_base_offset} + {w_swing2[15], w_swing2} +
                       {{(17 - TRIM_W){w_trim2[TRIM_W-1]}}, w_trim2};

    // stage 3: slew limiting and output register
    logic signed [ANGLE_W-1:0] r_raw3;
    t_item_ctl                 r_ctl3;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_raw3 <= w_raw_sum[15:0];
            r_ctl3 <= r_ctl2;
        end
    end

    sjag_slew_limiter u_slew_limiter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v3),
        .i_ctl       (r_ctl3),
        .i_raw       (r_raw3),
        .i_step      (w_step),
        .o_take      (w_take3),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_busy |-> o_in_stall)
        else $error("input accepted while slew step is recomputed");

    a_step_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step_busy |-> (w_step >= (STEP_FLOOR + STEP_MARGIN)))
        else $error("slew step below floor");

    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv1 && !r_in.enable) |=> ((r_phase_acc == 16'd0) && !r_prev_known))
        else $error("disabled tick did not clear phase");

    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv1 && r_in.enable && w_new_run) |=> (r_phase_acc == (16'd0 - {1'b0, r_phase_inc})))
        else $error("phase not restarted on mode change");

endmodule

### tb/sv/joint_angle_checker.sv
`timescale 1ns / 1ps
// Scoreboard for serpentine_joint_angle_generator. It watches the tick, angle and register
// channels, predicts every servo target with its own gait model and compares field by field.
// Depends on sjag_pkg for the transaction types, mode codes and register indexes.
module joint_angle_checker import sjag_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_clamps
);

    localparam int          JOINTS       = JOINT_COUNT_DEF;
    localparam int          SINE_DEPTH   = SINE_DEPTH_DEF;
    localparam int          MIN_STEP     = 384;
    localparam int          STEP_PAD     = 192;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    logic [2:0]         slot;
    logic signed [14:0] base;
    logic [12:0]        amp;
    logic [14:0]        inc;

    logic [15:0]        phase_acc;
    logic [1:0]         last_mode;
    bit                 mode_seen;
    logic signed [15:0] prior_angle;
    bit                 target_seen;
    logic [15:0]        clamp_cnt;

    t_out expected_angles[$];

    // Q15 sine of a Q16 turn, rational approximation of each half wave
    function automatic int sine_q15(input logic [15:0] t);
        longint m;
        longint den;
        longint s;
        m   = longint'(t[14:0]) * (longint'(32768) - longint'(t[14:0]));
        den = (longint'(5) << 28) - m;
        s   = ((m << 17) + den / 2) / den;
        return t[15] ? -int'(s) : int'(s);
    endfunction

    function automatic int table_sine(input logic [15:0] ph);
        longint idx;
        idx = (longint'(ph) * SINE_DEPTH) >> 16;
        return sine_q15(16'((idx * 65536) / SINE_DEPTH));
    endfunction

    function automatic int round_q15(input longint p);
        if (p >= 0) return int'((p + 16384) >>> 15);
        return -int'((16384 - p) >>> 15);
    endfunction

    function automatic int round_ratio(input int num, input int den);
        if (num >= 0) return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    task automatic flag(input string msg);
        $display("%0t ns angle check: %s", $time, msg);
        o_errors++;
    endtask

    task automatic advance_gait(input t_in item);
        int          n;
        int          k;
        int          raw;
        int          lim;
        int          delta;
        logic [15:0] ph;
        longint      p;
        t_out        res;
        if (!item.enable) begin
            phase_acc   = '0;
            mode_seen   = 1'b0;
            target_seen = 1'b0;
            return;
        end
        if (!mode_seen || last_mode != item.mode) begin
            last_mode   = item.mode;
            mode_seen   = 1'b1;
            phase_acc   = '0;
            target_seen = 1'b0;
        end
        phase_acc = phase_acc - {1'b0, inc};
        if (slot >= JOINTS) return;

        n  = JOINTS - 1 - int'(slot);
        k  = 2 * n - JOINTS + 1;
        ph = 16'((n * 65536 + 3) / 6);
        if (item.mode == MODE_LATERAL) ph = ph + QUARTER_TURN;
        ph  = ph + phase_acc;
        raw = int'(base) + round_q15(longint'(amp) * table_sine(ph));
        case (item.mode)
            MODE_FORWARD:  raw += round_ratio(k * 256, JOINTS);
            MODE_CIRCULAR: raw -= round_ratio(k * 480, JOINTS);
            MODE_TURN_R:   raw += round_ratio(k * 480, JOINTS);
            default: ;
        endcase

        res.clamped = 1'b0;
        if (target_seen) begin
            p   = 2 * longint'(amp) * sine_q15({2'b00, inc[14:1]});
            lim = int'((p + 16384) >>> 15);
            if (lim < MIN_STEP) lim = MIN_STEP;
            lim   = lim + STEP_PAD;
            delta = raw - int'(prior_angle);
            if (delta > lim) begin
                raw         = int'(prior_angle) + lim;
                res.clamped = 1'b1;
            end else if (delta < -lim) begin
                raw         = int'(prior_angle) - lim;
                res.clamped = 1'b1;
            end
            if (res.clamped) clamp_cnt = clamp_cnt + 16'd1;
        end
        prior_angle      = 16'(raw);
        target_seen      = 1'b1;
        res.target_angle = 16'(raw);
        res.clamp_total  = clamp_cnt;
        expected_angles.push_back(res);
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            slot        = '0;
            base        = '0;
            amp         = 13'd2880;
            inc         = 15'd2949;
            phase_acc   = '0;
            last_mode   = MODE_FORWARD;
            mode_seen   = 1'b0;
            prior_angle = '0;
            target_seen = 1'b0;
            clamp_cnt   = '0;
            expected_angles.delete();
        end else begin
            if (i_in_valid && !i_in_stall) advance_gait(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (i_out_data.clamped === 1'b1) o_clamps++;
                if (expected_angles.size() == 0) begin
                    flag($sformatf("unexpected angle %0d",
                                   $signed(i_out_data.target_angle)));
                end else begin
                    want = expected_angles.pop_front();
                    if (i_out_data.target_angle !== want.target_angle)
                        flag($sformatf("angle #%0d target_angle %0d, want %0d", o_checked,
                                       $signed(i_out_data.target_angle),
                                       $signed(want.target_angle)));
                    if (i_out_data.clamped !== want.clamped)
                        flag($sformatf("angle #%0d clamped %b, want %b", o_checked,
                                       i_out_data.clamped, want.clamped));
                    if (i_out_data.clamp_total !== want.clamp_total)
                        flag($sformatf("angle #%0d clamp_total %0d, want %0d", o_checked,
                                       i_out_data.clamp_total, want.clamp_total));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_JOINT_SLOT:  slot = i_cfg_data[2:0];
                    CFG_BASE_OFFSET: base = i_cfg_data;
                    CFG_SWING_AMP:   amp  = i_cfg_data[12:0];
                    CFG_PHASE_INC:   inc  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_angles.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the serpentine_joint_angle_generator bench: clock, reset, tick and register stimulus,
// output back-pressure and the verdict. Depends on sjag_pkg, the block and joint_angle_checker.
module testbench;
    import sjag_pkg::*;

    localparam int PHASE_TICKS = 68;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int err_count;
    int pending;
    int checked;
    int clamps;

    int src_idle_pct;
    int dst_idle_pct = 80;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int ticks_sent   = 0;
    int cfg_writes   = 0;
    int settings     = 0;

    logic [1:0]            gait_mode;
    logic [CFG_IDX_W-1:0]  reg_idx_q[$];
    logic [CFG_DATA_W-1:0] reg_val_q[$];

    serpentine_joint_angle_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    joint_angle_checker scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (err_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_clamps    (clamps)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("timeout: %0d angles still expected", pending);
        $display("testbench: errors");
        $finish;
    end

    // receiver back-pressure; a long hold-off starts whenever hold_req moves on
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= $urandom_range(400, 250);
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < dst_idle_pct);
        end
    end

    task automatic send_tick(input bit en, input logic [1:0] md);
        bit stalled;
        t_in item;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.enable = en;
        item.mode   = md;
        in_valid   <= 1'b1;
        in_data    <= item;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        ticks_sent++;
    endtask

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_idx_q.push_back(idx);
        reg_val_q.push_back(val);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        do @(negedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs();
        int k;
        bit rdy;
        for (k = 0; k < reg_idx_q.size(); k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx_q[k];
            cfg_data  <= reg_val_q[k];
            do begin
                @(negedge clk);
                rdy = cfg_ready;
                @(posedge clk);
            end while (!rdy);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
        reg_idx_q.delete();
        reg_val_q.delete();
        settings++;
    endtask

    task automatic run_phase(input int idx);
        int left;
        int run;
        int j;
        int roll;
        int b;
        wait_drained();
        if (idx == 0) queue_reg(CFG_JOINT_SLOT, '0);
        else if (idx == 1) queue_reg(CFG_JOINT_SLOT, 15'(JOINT_COUNT_DEF - 1));
        else if (idx % 5 == 3) queue_reg(CFG_JOINT_SLOT, 15'($urandom_range(7, JOINT_COUNT_DEF)));
        else queue_reg(CFG_JOINT_SLOT, 15'($urandom_range(JOINT_COUNT_DEF - 1)));
        if (idx == 0) b = -11520;
        else if (idx == 1) b = 11520;
        else if (idx == 7) b = int'($urandom_range(32767)) - 16384;
        else b = int'($urandom_range(23040)) - 11520;
        queue_reg(CFG_BASE_OFFSET, 15'(b));
        if ($urandom_range(2) == 0)
            queue_reg(CFG_PHASE_INC + 3'($urandom_range(4, 1)), 15'($urandom));
        if (idx == 0) queue_reg(CFG_SWING_AMP, 15'd5760);
        else if (idx == 1) queue_reg(CFG_SWING_AMP, '0);
        else if (idx == 2) queue_reg(CFG_SWING_AMP, 15'h1FFF);
        else queue_reg(CFG_SWING_AMP, 15'($urandom_range(5760)));
        if (idx == 0) queue_reg(CFG_PHASE_INC, 15'h7FFF);
        else if (idx == 1) queue_reg(CFG_PHASE_INC, '0);
        else if ($urandom_range(1) == 0) queue_reg(CFG_PHASE_INC, 15'($urandom_range(4000)));
        else queue_reg(CFG_PHASE_INC, 15'($urandom_range(32767)));
        write_regs();
        if (idx % 5 == 4) hold_req <= hold_req + 1;

        // the first run keeps the previous gait so the new settings hit the slew limiter
        left = PHASE_TICKS;
        while (left > 0) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                run = $urandom_range(24, 3);
                for (j = 0; j < run && left > 0; j++) begin
                    send_tick(1'b1, gait_mode);
                    left--;
                end
                if ($urandom_range(1) == 0) gait_mode = 2'($urandom_range(3));
            end else if (roll < 90) begin
                send_tick(1'b0, 2'($urandom_range(3)));
                left--;
            end else begin
                send_tick(1'($urandom_range(1)), 2'($urandom_range(3)));
                left--;
            end
        end
    endtask

    initial begin
        int regime;
        int ph;
        int w;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        src_idle_pct = 6;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every gait, disable, restart
        repeat (3) send_tick(1'b1, MODE_FORWARD);
        repeat (3) send_tick(1'b1, MODE_LATERAL);
        repeat (2) send_tick(1'b1, MODE_CIRCULAR);
        repeat (3) send_tick(1'b1, MODE_TURN_R);
        send_tick(1'b0, MODE_TURN_R);
        send_tick(1'b0, MODE_LATERAL);
        repeat (2) send_tick(1'b1, MODE_FORWARD);

        // slot past the body: phase and mode still tracked, no angles
        wait_drained();
        queue_reg(CFG_JOINT_SLOT, 15'd7);
        queue_reg(CFG_BASE_OFFSET, 15'(-11520));
        queue_reg(CFG_SWING_AMP, 15'd5760);
        queue_reg(CFG_PHASE_INC, 15'h7FFF);
        write_regs();
        repeat (2) send_tick(1'b1, MODE_FORWARD);
        send_tick(1'b1, MODE_LATERAL);

        wait_drained();
        queue_reg(CFG_JOINT_SLOT, 15'(JOINT_COUNT_DEF - 1));
        queue_reg(CFG_BASE_OFFSET, 15'd11520);
        queue_reg(CFG_SWING_AMP, '0);
        queue_reg(CFG_PHASE_INC, '0);
        write_regs();
        repeat (2) send_tick(1'b1, MODE_LATERAL);

        // full-scale jump in the neutral angle against the slew limit
        wait_drained();
        queue_reg(CFG_BASE_OFFSET, 15'(-11520));
        write_regs();
        repeat (3) send_tick(1'b1, MODE_LATERAL);
        gait_mode = MODE_LATERAL;

        for (regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    src_idle_pct = 6;
                    dst_idle_pct <= 80;
                end
                1: begin
                    src_idle_pct = 80;
                    dst_idle_pct <= 6;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct <= 0;
                end
            endcase
            for (ph = 0; ph < 5; ph++) run_phase(regime * 5 + ph);
        end

        in_valid <= 1'b0;
        for (w = 0; w < 20000 && pending != 0; w++) @(negedge clk);
        repeat (10) @(posedge clk);

        $display("run summary: %0d ticks, %0d register settings in %0d writes", ticks_sent,
                 settings, cfg_writes);
        $display("run summary: %0d angles checked, %0d clamped, %0d mismatches", checked,
                 clamps, err_count);
        if (pending != 0) $display("%0d expected angles never arrived", pending);
        if (err_count == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
